// ----- hw/rtl/sqt_pkg.sv -----
// Shared constants, types and helper functions for the sprite quad transform.
package sqt_pkg;

  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int SUBPIXEL_BITS_DEF  = 4;

  localparam int DIM_W   = 12;
  localparam int COORD_W = 20;
  localparam int SCALE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int OUT_W   = 24;

  localparam int CORDIC_STEPS    = 30;
  localparam int STEPS_PER_STG   = 2;
  localparam int CORDIC_ITER_STG = CORDIC_STEPS / STEPS_PER_STG;
  localparam int CORDIC_LAT      = CORDIC_ITER_STG + 1;
  localparam int SCALE_LAT       = 2;
  localparam int ROT_LAT         = 3;

  localparam int X_W = 34;
  localparam int Z_W = 33;

  localparam logic signed [X_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458908, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
    30'd20,        30'd10,        30'd5,         30'd3,        30'd1
  };

  localparam logic [OUT_W-1:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  // Width of a local corner minus the origin, in subpixels.
  function automatic int diff_width(input int sp);
    int lw;
    lw = DIM_W + 1 + sp;
    return ((lw > COORD_W) ? lw : COORD_W) + 1;
  endfunction

endpackage

// ----- hw/rtl/sqt_cordic.sv -----
// Pipelined CORDIC that produces rounded and clamped cosine and sine of the angle.
module sqt_cordic import sqt_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [ANGLE_W-1:0]               angle,
  output logic                             out_valid,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_q,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_q
);

  localparam int CS_W = TRIG_FRAC_BITS + 2;
  localparam int Q_W  = TRIG_FRAC_BITS + 4;
  localparam int SH   = 30 - TRIG_FRAC_BITS;
  localparam logic signed [X_W-1:0] RND = X_W'(1) << (29 - TRIG_FRAC_BITS);
  localparam logic signed [Q_W-1:0] LIM = Q_W'(1) << TRIG_FRAC_BITS;

  logic signed [X_W-1:0] x_r [CORDIC_ITER_STG];
  logic signed [X_W-1:0] y_r [CORDIC_ITER_STG];
  logic signed [Z_W-1:0] z_r [CORDIC_ITER_STG];
  quad_t                 q_r [CORDIC_ITER_STG];
  logic                  v_r [CORDIC_ITER_STG];

  for (genvar k = 0; k < CORDIC_ITER_STG; k++) begin : g_stg
    logic signed [X_W-1:0] x_in, y_in, x_nxt, y_nxt;
    logic signed [Z_W-1:0] z_in, z_nxt;
    quad_t                 q_in;
    logic                  v_in;

    if (k == 0) begin : g_first
      assign x_in = CORDIC_GAIN;
      assign y_in = '0;
      assign z_in = {3'b000, angle[ANGLE_W-3:0], 16'h0000};
      assign q_in = quad_t'(angle[ANGLE_W-1:ANGLE_W-2]);
      assign v_in = in_valid;
    end else begin : g_next
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign z_in = z_r[k-1];
      assign q_in = q_r[k-1];
      assign v_in = v_r[k-1];
    end

    always_comb begin
      logic signed [X_W-1:0] xs, ys;
      x_nxt = x_in;
      y_nxt = y_in;
      z_nxt = z_in;
      for (int j = 0; j < STEPS_PER_STG; j++) begin
        xs = x_nxt >>> (k * STEPS_PER_STG + j);
        ys = y_nxt >>> (k * STEPS_PER_STG + j);
        if (!z_nxt[Z_W-1]) begin
          x_nxt = x_nxt - ys;
          y_nxt = y_nxt + xs;
          z_nxt = z_nxt - $signed({3'b000, ATAN_TAB[k * STEPS_PER_STG + j]});
        end else begin
          x_nxt = x_nxt + ys;
          y_nxt = y_nxt - xs;
          z_nxt = z_nxt + $signed({3'b000, ATAN_TAB[k * STEPS_PER_STG + j]});
        end
      end
    end

    always_ff @(posedge clk) begin
      x_r[k] <= x_nxt;
      y_r[k] <= y_nxt;
      z_r[k] <= z_nxt;
      q_r[k] <= q_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end
  end

  logic signed [X_W-1:0]  xr, yr;
  logic signed [Q_W-1:0]  xq, yq;
  logic signed [CS_W-1:0] xc, yc, cos_nxt, sin_nxt;
  logic signed [CS_W-1:0] cos_r, sin_r;
  logic                   vld_r;

  always_comb begin
    xr = x_r[CORDIC_ITER_STG-1] + RND;
    yr = y_r[CORDIC_ITER_STG-1] + RND;
    xq = $signed(xr[X_W-1:SH]);
    yq = $signed(yr[X_W-1:SH]);
    if (xq > LIM) begin
      xc = CS_W'(LIM);
    end else if (xq < -LIM) begin
      xc = CS_W'(-LIM);
    end else begin
      xc = CS_W'(xq);
    end
    if (yq > LIM) begin
      yc = CS_W'(LIM);
    end else if (yq < -LIM) begin
      yc = CS_W'(-LIM);
    end else begin
      yc = CS_W'(yq);
    end
  end

  always_comb begin
    unique case (q_r[CORDIC_ITER_STG-1])
      QUAD_0: begin
        cos_nxt = xc;
        sin_nxt = yc;
      end
      QUAD_90: begin
        cos_nxt = -yc;
        sin_nxt = xc;
      end
      QUAD_180: begin
        cos_nxt = -xc;
        sin_nxt = -yc;
      end
      QUAD_270: begin
        cos_nxt = yc;
        sin_nxt = -xc;
      end
      default: begin
        cos_nxt = xc;
        sin_nxt = yc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= v_r[CORDIC_ITER_STG-1];
    end
  end

  assign out_valid = vld_r;
  assign cos_q     = cos_r;
  assign sin_q     = sin_r;

endmodule

// ----- hw/rtl/sqt_scale.sv -----
// Two-stage front end that offsets the local corners by the origin and applies the scale.
module sqt_scale import sqt_pkg::*; #(
  parameter int SUBPIXEL_BITS = SUBPIXEL_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic [DIM_W-1:0]                                       width,
  input  logic [DIM_W-1:0]                                       height,
  input  logic signed [COORD_W-1:0]                              origin_x,
  input  logic signed [COORD_W-1:0]                              origin_y,
  input  logic signed [SCALE_W-1:0]                              scale_x,
  input  logic signed [SCALE_W-1:0]                              scale_y,
  output logic signed [diff_width(SUBPIXEL_BITS)+SCALE_W-1:0]    mx0,
  output logic signed [diff_width(SUBPIXEL_BITS)+SCALE_W-1:0]    mx1,
  output logic signed [diff_width(SUBPIXEL_BITS)+SCALE_W-1:0]    my0,
  output logic signed [diff_width(SUBPIXEL_BITS)+SCALE_W-1:0]    my1
);

  localparam int DIFF_W = diff_width(SUBPIXEL_BITS);
  localparam int MX_W   = DIFF_W + SCALE_W;

  logic signed [DIFF_W-1:0]  lx, ly, ox, oy;
  logic signed [DIFF_W-1:0]  dx0_r, dx1_r, dy0_r, dy1_r;
  logic signed [SCALE_W-1:0] sx_r, sy_r;
  logic signed [MX_W-1:0]    mx0_r, mx1_r, my0_r, my1_r;

  assign lx = $signed(DIFF_W'(width) << SUBPIXEL_BITS);
  assign ly = $signed(DIFF_W'(height) << SUBPIXEL_BITS);
  assign ox = DIFF_W'(origin_x);
  assign oy = DIFF_W'(origin_y);

  always_ff @(posedge clk) begin
    dx0_r <= -ox;
    dx1_r <= lx - ox;
    dy0_r <= -oy;
    dy1_r <= ly - oy;
    sx_r  <= scale_x;
    sy_r  <= scale_y;
  end

  always_ff @(posedge clk) begin
    mx0_r <= dx0_r * sx_r;
    mx1_r <= dx1_r * sx_r;
    my0_r <= dy0_r * sy_r;
    my1_r <= dy1_r * sy_r;
  end

  assign mx0 = mx0_r;
  assign mx1 = mx1_r;
  assign my0 = my0_r;
  assign my1 = my1_r;

endmodule

// ----- hw/rtl/sqt_rotate.sv -----
// Three-stage back end that rotates, rounds, translates and saturates the four corners.
module sqt_rotate import sqt_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int MX_W           = diff_width(SUBPIXEL_BITS_DEF) + SCALE_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic signed [MX_W-1:0]           mx0,
  input  logic signed [MX_W-1:0]           mx1,
  input  logic signed [MX_W-1:0]           my0,
  input  logic signed [MX_W-1:0]           my1,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_q,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_q,
  input  logic signed [COORD_W-1:0]        pos_x,
  input  logic signed [COORD_W-1:0]        pos_y,
  output logic                             out_valid,
  output logic [OUT_W-1:0]                 corner_x [4],
  output logic [OUT_W-1:0]                 corner_y [4]
);

  localparam int CS_W  = TRIG_FRAC_BITS + 2;
  localparam int PW    = MX_W + CS_W;
  localparam int SUM_W = PW + 2;
  localparam int SH    = 8 + TRIG_FRAC_BITS;
  localparam int SW    = SUM_W - SH;
  localparam int AW    = SW + 1;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (SH - 1);

  logic signed [PW-1:0]      pxc_r [2];
  logic signed [PW-1:0]      pxs_r [2];
  logic signed [PW-1:0]      pyc_r [2];
  logic signed [PW-1:0]      pys_r [2];
  logic signed [COORD_W-1:0] px1_r, py1_r, px2_r, py2_r;
  logic                      v1_r, v2_r, v3_r;

  logic signed [SUM_W-1:0]   sum_x_r [4];
  logic signed [SUM_W-1:0]   sum_y_r [4];
  logic [OUT_W-1:0]          out_x_r [4];
  logic [OUT_W-1:0]          out_y_r [4];

  always_ff @(posedge clk) begin
    pxc_r[0] <= mx0 * cos_q;
    pxs_r[0] <= mx0 * sin_q;
    pxc_r[1] <= mx1 * cos_q;
    pxs_r[1] <= mx1 * sin_q;
    pyc_r[0] <= my0 * cos_q;
    pys_r[0] <= my0 * sin_q;
    pyc_r[1] <= my1 * cos_q;
    pys_r[1] <= my1 * sin_q;
    px1_r    <= pos_x;
    py1_r    <= pos_y;
    px2_r    <= px1_r;
    py2_r    <= py1_r;
  end

  for (genvar n = 0; n < 4; n++) begin : g_corner
    localparam int XI = (n == 1 || n == 2) ? 1 : 0;
    localparam int YI = (n >= 2) ? 1 : 0;

    logic signed [SW-1:0] sx_sh, sy_sh;
    logic signed [AW-1:0] ax, ay;
    logic [OUT_W-1:0]     ox_nxt, oy_nxt;

    always_ff @(posedge clk) begin
      sum_x_r[n] <= SUM_W'(pxc_r[XI]) - SUM_W'(pys_r[YI]) + HALF;
      sum_y_r[n] <= SUM_W'(pxs_r[XI]) + SUM_W'(pyc_r[YI]) + HALF;
    end

    always_comb begin
      sx_sh = $signed(sum_x_r[n][SUM_W-1:SH]);
      sy_sh = $signed(sum_y_r[n][SUM_W-1:SH]);
      ax    = AW'(sx_sh) + AW'(px2_r);
      ay    = AW'(sy_sh) + AW'(py2_r);
      if (ax[AW-1:OUT_W-1] == {(AW-OUT_W+1){ax[AW-1]}}) begin
        ox_nxt = ax[OUT_W-1:0];
      end else begin
        ox_nxt = ax[AW-1] ? OUT_MIN : OUT_MAX;
      end
      if (ay[AW-1:OUT_W-1] == {(AW-OUT_W+1){ay[AW-1]}}) begin
        oy_nxt = ay[OUT_W-1:0];
      end else begin
        oy_nxt = ay[AW-1] ? OUT_MIN : OUT_MAX;
      end
    end

    always_ff @(posedge clk) begin
      out_x_r[n] <= ox_nxt;
      out_y_r[n] <= oy_nxt;
    end

    assign corner_x[n] = out_x_r[n];
    assign corner_y[n] = out_y_r[n];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;

endmodule

// ----- hw/rtl/sprite_quad_transform_core.sv -----
// Top level of the sprite quad transform: CORDIC, scale front end, delay lines and rotation.
// The block takes one sprite beat in every clock cycle and never raises busy after reset.
// Each beat taken gives one result beat, marked by out_valid for one
// cycle; the latency is set by the sine and cosine unit, a CORDIC of 15 register stages
// with two iterations each plus one rounding stage, followed by three rotation stages.
// The receiver cannot stall, so results must be captured in the cycle they appear.
module sprite_quad_transform_core import sqt_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int SUBPIXEL_BITS  = SUBPIXEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [DIM_W-1:0]          in_width,
  input  logic [DIM_W-1:0]          in_height,
  input  logic signed [COORD_W-1:0] in_origin_x,
  input  logic signed [COORD_W-1:0] in_origin_y,
  input  logic signed [SCALE_W-1:0] in_scale_x,
  input  logic signed [SCALE_W-1:0] in_scale_y,
  input  logic [ANGLE_W-1:0]        in_angle,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  output logic                      out_valid,
  output logic signed [OUT_W-1:0]   out_bl_x,
  output logic signed [OUT_W-1:0]   out_bl_y,
  output logic signed [OUT_W-1:0]   out_br_x,
  output logic signed [OUT_W-1:0]   out_br_y,
  output logic signed [OUT_W-1:0]   out_tr_x,
  output logic signed [OUT_W-1:0]   out_tr_y,
  output logic signed [OUT_W-1:0]   out_tl_x,
  output logic signed [OUT_W-1:0]   out_tl_y
);

  localparam int DIFF_W  = diff_width(SUBPIXEL_BITS);
  localparam int MX_W    = DIFF_W + SCALE_W;
  localparam int CS_W    = TRIG_FRAC_BITS + 2;
  localparam int GEO_DLY = CORDIC_LAT - SCALE_LAT;

  logic                   busy_r;
  logic                   accept;
  logic                   trig_valid;
  logic signed [CS_W-1:0] cos_q, sin_q;
  logic signed [MX_W-1:0] mx0, mx1, my0, my1;

  logic signed [MX_W-1:0]    mx0_d_r [GEO_DLY];
  logic signed [MX_W-1:0]    mx1_d_r [GEO_DLY];
  logic signed [MX_W-1:0]    my0_d_r [GEO_DLY];
  logic signed [MX_W-1:0]    my1_d_r [GEO_DLY];
  logic signed [COORD_W-1:0] px_d_r  [CORDIC_LAT];
  logic signed [COORD_W-1:0] py_d_r  [CORDIC_LAT];

  logic [OUT_W-1:0] corner_x [4];
  logic [OUT_W-1:0] corner_y [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  sqt_cordic #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .angle    (in_angle),
    .out_valid(trig_valid),
    .cos_q    (cos_q),
    .sin_q    (sin_q)
  );

  sqt_scale #(
    .SUBPIXEL_BITS(SUBPIXEL_BITS)
  ) u_scale (
    .clk     (clk),
    .width   (in_width),
    .height  (in_height),
    .origin_x(in_origin_x),
    .origin_y(in_origin_y),
    .scale_x (in_scale_x),
    .scale_y (in_scale_y),
    .mx0     (mx0),
    .mx1     (mx1),
    .my0     (my0),
    .my1     (my1)
  );

  always_ff @(posedge clk) begin
    mx0_d_r[0] <= mx0;
    mx1_d_r[0] <= mx1;
    my0_d_r[0] <= my0;
    my1_d_r[0] <= my1;
    for (int i = 1; i < GEO_DLY; i++) begin
      mx0_d_r[i] <= mx0_d_r[i-1];
      mx1_d_r[i] <= mx1_d_r[i-1];
      my0_d_r[i] <= my0_d_r[i-1];
      my1_d_r[i] <= my1_d_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    px_d_r[0] <= in_pos_x;
    py_d_r[0] <= in_pos_y;
    for (int i = 1; i < CORDIC_LAT; i++) begin
      px_d_r[i] <= px_d_r[i-1];
      py_d_r[i] <= py_d_r[i-1];
    end
  end

  sqt_rotate #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .MX_W          (MX_W)
  ) u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (trig_valid),
    .mx0      (mx0_d_r[GEO_DLY-1]),
    .mx1      (mx1_d_r[GEO_DLY-1]),
    .my0      (my0_d_r[GEO_DLY-1]),
    .my1      (my1_d_r[GEO_DLY-1]),
    .cos_q    (cos_q),
    .sin_q    (sin_q),
    .pos_x    (px_d_r[CORDIC_LAT-1]),
    .pos_y    (py_d_r[CORDIC_LAT-1]),
    .out_valid(out_valid),
    .corner_x (corner_x),
    .corner_y (corner_y)
  );

  assign out_bl_x = $signed(corner_x[0]);
  assign out_bl_y = $signed(corner_y[0]);
  assign out_br_x = $signed(corner_x[1]);
  assign out_br_y = $signed(corner_y[1]);
  assign out_tr_x = $signed(corner_x[2]);
  assign out_tr_y = $signed(corner_y[2]);
  assign out_tl_x = $signed(corner_x[3]);
  assign out_tl_y = $signed(corner_y[3]);

endmodule

// ----- dv/tb_sprite_quad_transform_core.sv -----
// Self-checking testbench for the sprite quad transform, with a fixed-point predictor of the four corners.
module tb_sprite_quad_transform_core;
  import sqt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRIG_FRAC   = TRIG_FRAC_BITS_DEF;
  localparam int SUBPIX      = SUBPIXEL_BITS_DEF;
  localparam int ROT_STEPS   = 30;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 1500;

  localparam longint CORDIC_K = 64'sd652032874;
  localparam longint ARCTAN_STEP [ROT_STEPS] = '{
    536870912, 316933406, 167458908, 85004756, 42667331,
    21354465,  10679838,  5340245,   2670163,  1335087,
    667544,    333772,    166886,    83443,    41722,
    20861,     10430,     5215,      2608,     1304,
    652,       326,       163,       81,       41,
    20,        10,        5,         3,        1
  };

  typedef struct packed {
    logic                      drain;
    logic [DIM_W-1:0]          width;
    logic [DIM_W-1:0]          height;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic [ANGLE_W-1:0]        angle;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } sprite_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] bl_x;
    logic signed [OUT_W-1:0] bl_y;
    logic signed [OUT_W-1:0] br_x;
    logic signed [OUT_W-1:0] br_y;
    logic signed [OUT_W-1:0] tr_x;
    logic signed [OUT_W-1:0] tr_y;
    logic signed [OUT_W-1:0] tl_x;
    logic signed [OUT_W-1:0] tl_y;
  } corners_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic out_valid;
  sprite_t cur = '0;
  corners_t seen;
  corners_t want;
  sprite_t nxt;

  sprite_t  sprites_pending[$];
  corners_t corners_due[$];
  logic beat_taken = 1'b0;
  int idle_left = 0;
  bit idle_on = 1'b1;
  int mismatches = 0;
  int cycle_count = 0;

  sprite_quad_transform_core #(
    .TRIG_FRAC_BITS(TRIG_FRAC),
    .SUBPIXEL_BITS (SUBPIX)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_width   (cur.width),
    .in_height  (cur.height),
    .in_origin_x(cur.origin_x),
    .in_origin_y(cur.origin_y),
    .in_scale_x (cur.scale_x),
    .in_scale_y (cur.scale_y),
    .in_angle   (cur.angle),
    .in_pos_x   (cur.pos_x),
    .in_pos_y   (cur.pos_y),
    .out_valid  (out_valid),
    .out_bl_x   (seen.bl_x),
    .out_bl_y   (seen.bl_y),
    .out_br_x   (seen.br_x),
    .out_br_y   (seen.br_y),
    .out_tr_x   (seen.tr_x),
    .out_tr_y   (seen.tr_y),
    .out_tl_x   (seen.tl_x),
    .out_tl_y   (seen.tl_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Sine and cosine in Q1.TRIG_FRAC: CORDIC within the quadrant, then exact quadrant folding.
  function automatic void sin_cos_lookup(logic [ANGLE_W-1:0] ang, output longint cosv,
                                         output longint sinv);
    longint cx, cy, cz, xs, ys, lim;
    quad_t quadrant;
    int i;
    cx = CORDIC_K;
    cy = 0;
    cz = longint'({ang[13:0], 16'd0});
    for (i = 0; i < ROT_STEPS; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cz >= 0) begin
        cx = cx - ys;
        cy = cy + xs;
        cz = cz - ARCTAN_STEP[i];
      end else begin
        cx = cx + ys;
        cy = cy - xs;
        cz = cz + ARCTAN_STEP[i];
      end
    end
    lim = 64'sd1 <<< TRIG_FRAC;
    cx = clamp_range((cx + (64'sd1 <<< (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC), -lim, lim);
    cy = clamp_range((cy + (64'sd1 <<< (29 - TRIG_FRAC))) >>> (30 - TRIG_FRAC), -lim, lim);
    quadrant = quad_t'(ang[15:14]);
    case (quadrant)
      QUAD_0: begin
        cosv = cx;
        sinv = cy;
      end
      QUAD_90: begin
        cosv = -cy;
        sinv = cx;
      end
      QUAD_180: begin
        cosv = -cx;
        sinv = -cy;
      end
      default: begin
        cosv = cy;
        sinv = -cx;
      end
    endcase
  endfunction

  function automatic void place_corner(longint lx, longint ly, sprite_t sp, longint cosv,
                                       longint sinv, output logic signed [OUT_W-1:0] qx,
                                       output logic signed [OUT_W-1:0] qy);
    longint mx, my, rx, ry, half;
    int sh;
    sh = 8 + TRIG_FRAC;
    half = 64'sd1 <<< (sh - 1);
    mx = (lx - longint'(sp.origin_x)) * longint'(sp.scale_x);
    my = (ly - longint'(sp.origin_y)) * longint'(sp.scale_y);
    rx = ((mx * cosv - my * sinv + half) >>> sh) + longint'(sp.pos_x);
    ry = ((mx * sinv + my * cosv + half) >>> sh) + longint'(sp.pos_y);
    qx = OUT_W'(clamp_range(rx, -(64'sd1 <<< (OUT_W - 1)), (64'sd1 <<< (OUT_W - 1)) - 1));
    qy = OUT_W'(clamp_range(ry, -(64'sd1 <<< (OUT_W - 1)), (64'sd1 <<< (OUT_W - 1)) - 1));
  endfunction

  function automatic corners_t transform_quad(sprite_t sp);
    corners_t q;
    longint cosv, sinv, wl, hl;
    sin_cos_lookup(sp.angle, cosv, sinv);
    wl = longint'(sp.width) <<< SUBPIX;
    hl = longint'(sp.height) <<< SUBPIX;
    place_corner(0, 0, sp, cosv, sinv, q.bl_x, q.bl_y);
    place_corner(wl, 0, sp, cosv, sinv, q.br_x, q.br_y);
    place_corner(wl, hl, sp, cosv, sinv, q.tr_x, q.tr_y);
    place_corner(0, hl, sp, cosv, sinv, q.tl_x, q.tl_y);
    return q;
  endfunction

  function automatic sprite_t sprite(int w, int h, int ox, int oy, int sx, int sy, int ang,
                                     int px, int py, bit drain = 1'b0);
    sprite_t sp;
    sp.drain    = drain;
    sp.width    = DIM_W'(w);
    sp.height   = DIM_W'(h);
    sp.origin_x = COORD_W'(ox);
    sp.origin_y = COORD_W'(oy);
    sp.scale_x  = SCALE_W'(sx);
    sp.scale_y  = SCALE_W'(sy);
    sp.angle    = ANGLE_W'(ang);
    sp.pos_x    = COORD_W'(px);
    sp.pos_y    = COORD_W'(py);
    return sp;
  endfunction

  function automatic int signed_pick(int mag);
    int v;
    v = int'($urandom_range(0, mag));
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  task automatic check_field(string name, logic signed [OUT_W-1:0] exp_v,
                             logic signed [OUT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // The driver presents a new beat once the previous one was taken, with random idle bursts.
  always @(negedge clk) begin
    if (rst_n && (!start || beat_taken)) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (sprites_pending.size() > 0 &&
                   !(sprites_pending[0].drain && corners_due.size() > 0)) begin
        nxt = sprites_pending.pop_front();
        cur <= nxt;
        start <= 1'b1;
        if ($urandom_range(0, 63) == 0) idle_on = !idle_on;
        if (idle_on && sprites_pending.size() > 200 && $urandom_range(0, 3) == 0) begin
          idle_left = $urandom_range(1, 9);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    beat_taken <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (corners_due.size() == 0) begin
        $error("result beat arrived with no sprite outstanding");
        mismatches++;
      end else begin
        want = corners_due.pop_front();
        check_field("bl_x", want.bl_x, seen.bl_x);
        check_field("bl_y", want.bl_y, seen.bl_y);
        check_field("br_x", want.br_x, seen.br_x);
        check_field("br_y", want.br_y, seen.br_y);
        check_field("tr_x", want.tr_x, seen.tr_x);
        check_field("tr_y", want.tr_y, seen.tr_y);
        check_field("tl_x", want.tl_x, seen.tl_x);
        check_field("tl_y", want.tl_y, seen.tl_y);
      end
    end
    if (rst_n && start && !busy) corners_due.push_back(transform_quad(cur));
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    int w, h;
    // Directed sprites: field extremes, quadrant boundaries, degenerate sizes and saturation.
    sprites_pending.push_back(sprite(0, 0, 0, 0, 0, 0, 0, 0, 0));
    sprites_pending.push_back(sprite(16, 8, 0, 0, 256, 256, 0, 100, -100));
    sprites_pending.push_back(sprite(16, 8, 128, 64, 256, 256, 16384, 0, 0));
    sprites_pending.push_back(sprite(16, 8, 128, 64, 256, 256, 32768, 0, 0));
    sprites_pending.push_back(sprite(16, 8, 128, 64, 256, 256, 49152, 0, 0));
    sprites_pending.push_back(sprite(16, 8, 128, 64, 256, 256, 8192, 50, 50));
    sprites_pending.push_back(sprite(16, 8, 128, 64, 256, 256, 16383, 0, 0));
    sprites_pending.push_back(sprite(16, 8, 128, 64, 256, 256, 65535, 0, 0));
    sprites_pending.push_back(sprite(16, 8, 128, 64, 256, 256, 1, 0, 0));
    sprites_pending.push_back(sprite(0, 40, 7, -9, 300, 200, 12000, 1000, 2000, 1'b1));
    sprites_pending.push_back(sprite(40, 0, -7, 9, 200, 300, 40000, -1000, -2000));
    sprites_pending.push_back(sprite(32, 32, 256, 256, -256, 256, 0, 0, 0));
    sprites_pending.push_back(sprite(32, 32, 256, 256, 256, -512, 20000, 0, 0));
    sprites_pending.push_back(sprite(4095, 4095, -524288, -524288, 32767, 32767, 0,
                                     524287, 524287));
    sprites_pending.push_back(sprite(4095, 4095, 524287, 524287, -32768, -32768, 0,
                                     -524288, -524288));
    sprites_pending.push_back(sprite(4095, 4095, -524288, 524287, 32767, -32768, 30000,
                                     -524288, 524287));
    sprites_pending.push_back(sprite(4095, 4095, 0, 0, -32768, 32767, 50000, 524287,
                                     -524288));
    sprites_pending.push_back(sprite(4095, 1, 65520, 8, 256, 256, 0, 524287, 524287));
    sprites_pending.push_back(sprite(1, 4095, 8, 65520, 1, -1, 32768, -524288, 0));
    sprites_pending.push_back(sprite(100, 100, 800, 800, 32767, 32767, 8192, 0, 0, 1'b1));
    // Random sprites: mostly plausible ones, the rest with every field drawn over its full range.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 7) begin
        w = int'($urandom_range(0, 255));
        h = int'($urandom_range(0, 255));
        sprites_pending.push_back(sprite(w, h,
          int'($urandom_range(0, w * 16)), int'($urandom_range(0, h * 16)),
          signed_pick(1024), signed_pick(1024), int'($urandom_range(0, 65535)),
          signed_pick(131072), signed_pick(131072), (n % 400) == 399));
      end else begin
        sprites_pending.push_back(sprite(int'($urandom()), int'($urandom()),
          int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
          int'($urandom()), int'($urandom()), int'($urandom()), (n % 400) == 399));
      end
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (sprites_pending.size() != 0 || start || corners_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sqt_pkg.sv
hw/rtl/sqt_cordic.sv
hw/rtl/sqt_scale.sv
hw/rtl/sqt_rotate.sv
hw/rtl/sprite_quad_transform_core.sv
dv/tb_sprite_quad_transform_core.sv
